### rtl/core/openpgp_pkesk_extractor_assert.svh
// Assertion macros for the PKESK extractor. Clock aclk, reset aresetn in scope.
`ifndef OPENPGP_PKESK_EXTRACTOR_ASSERT_SVH
`define OPENPGP_PKESK_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PKESK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pkesk assertion failed");
`define PKESK_ASSERT_IMP(lbl, pre, post) \
    `PKESK_ASSERT(lbl, (pre) |-> (post))
`else
`define PKESK_ASSERT(lbl, prop)
`define PKESK_ASSERT_IMP(lbl, pre, post)
`endif
`endif

### rtl/core/pkesk_pkg.sv
`timescale 1ns / 1ps
package pkesk_pkg;

    localparam int KEY_CAPACITY = 64;
    localparam int NB_W         = 14;
    localparam int END_W        = 15;

    localparam logic [2:0] PH_TAG  = 3'd0;
    localparam logic [2:0] PH_NLEN = 3'd1;
    localparam logic [2:0] PH_N2   = 3'd2;
    localparam logic [2:0] PH_LENB = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;
    localparam logic [2:0] PH_BODY = 3'd5;
    localparam logic [2:0] PH_ERR  = 3'd6;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TAG       = 4'd1;
    localparam logic [3:0] ST_PARTIAL   = 4'd2;
    localparam logic [3:0] ST_OVERRUN   = 4'd3;
    localparam logic [3:0] ST_SHORT     = 4'd4;
    localparam logic [3:0] ST_VERSION   = 4'd5;
    localparam logic [3:0] ST_ALGO      = 4'd6;
    localparam logic [3:0] ST_MPI       = 4'd7;
    localparam logic [3:0] ST_POINT     = 4'd8;
    localparam logic [3:0] ST_SPACE     = 4'd9;
    localparam logic [3:0] ST_KEYBOUNDS = 4'd10;
    localparam logic [3:0] ST_SIZE      = 4'd11;
    localparam logic [3:0] ST_NOTFOUND  = 4'd12;
    localparam logic [3:0] ST_TRUNC     = 4'd13;

    localparam logic [1:0] KIND_KEYID  = 2'd0;
    localparam logic [1:0] KIND_POINT  = 2'd1;
    localparam logic [1:0] KIND_WRAP   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [5:0] TAG_PKESK   = 6'd1;
    localparam logic [7:0] PKESK_VER   = 8'd3;
    localparam logic [7:0] ALGO_ECDH   = 8'd18;
    localparam logic [7:0] POINT_UNCMP = 8'h04;
    localparam logic [NB_W-1:0] POINT_BYTES = NB_W'(65);

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] position;
        logic [7:0] value;
        logic       final_res;
        logic [3:0] status;
    } pkesk_res_t;

endpackage

### rtl/core/openpgp_pkesk_extractor.sv
`timescale 1ns / 1ps
`include "openpgp_pkesk_extractor_assert.svh"
// OpenPGP PKESK (v3, ECDH) extractor.
// Slave channel: one message byte per word on s_tdata, s_tlast on the final
// byte of a message. Master channel: extracted key ID, point X/Y and wrapped
// key bytes, each tagged by kind on m_tuser with its index in m_tdata. The
// word with m_tlast high closes the message and carries the status; earlier
// words are tentative until that status reads ok.
// Throughput: one byte per clock when not stalled. The parser state updates
// in the cycle a byte is taken and any result lands in the output register,
// so it appears on the master side in the cycle after the byte is accepted.
// Bytes with no result (headers, skipped packets) are consumed without output.
// Stall: while the output register holds an untaken word, s_tready follows
// m_tready, so a byte is still taken in the cycle the pending word leaves.
// Reset (synchronous, aresetn low) empties the output register and returns
// the parser to expecting a packet tag; taking the s_tlast word rearms it too.
module openpgp_pkesk_extractor #(
    parameter int KEY_CAPACITY = pkesk_pkg::KEY_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // position[7:0], value[15:8], status[19:16], zero
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import pkesk_pkg::*;

    logic       in_en;
    pkesk_res_t res;
    pkesk_res_t out_reg;
    logic       m_valid_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_en    = s_tvalid && s_tready;

    pkesk_parser #(
        .KEY_CAPACITY (KEY_CAPACITY)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_en   (in_en),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_en && res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_reg.status, out_reg.value, out_reg.position};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.final_res;

    `PKESK_ASSERT_IMP(a_status_closes, m_tvalid && m_tdata[19:16] != ST_OK, m_tlast)
    `PKESK_ASSERT_IMP(a_status_only_closes, m_tvalid && m_tuser == KIND_STATUS, m_tlast)
    `PKESK_ASSERT_IMP(a_no_overwrite, m_tvalid && !m_tready, !s_tready)

endmodule

### rtl/core/pkesk_parser.sv
`timescale 1ns / 1ps
`include "openpgp_pkesk_extractor_assert.svh"
module pkesk_parser #(
    parameter int KEY_CAPACITY = pkesk_pkg::KEY_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_en,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output pkesk_pkg::pkesk_res_t  res
);
    import pkesk_pkg::*;

    logic [2:0]       phase_reg,    phase_next;
    logic [2:0]       hdr_cnt_reg,  hdr_cnt_next;
    logic [31:0]      pkt_len_reg,  pkt_len_next;
    logic [31:0]      offset_reg,   offset_next;
    logic [5:0]       tag_reg,      tag_next;
    logic             open_reg,     open_next;
    logic [7:0]       mpi_hi_reg,   mpi_hi_next;
    logic [NB_W-1:0]  nb_reg,       nb_next;
    logic [7:0]       key_len_reg,  key_len_next;
    logic [END_W-1:0] key_end_reg,  key_end_next;
    logic             finished_reg, finished_next;
    logic [3:0]       err_reg,      err_next;
    logic             ver_ok_reg,   ver_ok_next;
    logic             algo_ok_reg,  algo_ok_next;
    logic             prefix_ok_reg, prefix_ok_next;

    logic [31:0]      off_inc;
    logic [END_W-1:0] pt_end;
    logic [END_W-1:0] pt_end_next;
    logic             do_enter;
    logic             emit;
    logic             point_ok;
    logic [1:0]       emit_kind;
    logic [7:0]       emit_pos;
    logic [3:0]       judge_st;
    logic [3:0]       final_st;

    assign off_inc     = (offset_reg == '1) ? offset_reg : offset_reg + 32'd1;
    assign pt_end      = END_W'(nb_reg) + END_W'(12);
    assign point_ok    = (nb_reg == POINT_BYTES) && ver_ok_reg && algo_ok_reg
                         && prefix_ok_reg;

    // header decode and body walk
    always_comb begin
        phase_next     = phase_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        pkt_len_next   = pkt_len_reg;
        offset_next    = offset_reg;
        tag_next       = tag_reg;
        open_next      = open_reg;
        mpi_hi_next    = mpi_hi_reg;
        nb_next        = nb_reg;
        key_len_next   = key_len_reg;
        key_end_next   = key_end_reg;
        finished_next  = finished_reg;
        err_next       = err_reg;
        ver_ok_next    = ver_ok_reg;
        algo_ok_next   = algo_ok_reg;
        prefix_ok_next = prefix_ok_reg;
        do_enter       = 1'b0;
        emit           = 1'b0;
        emit_kind      = KIND_STATUS;
        emit_pos       = 8'd0;

        case (phase_reg)
            PH_TAG: begin
                if (!in_byte[7]) begin
                    err_next   = ST_TAG;
                    phase_next = PH_ERR;
                end else if (in_byte[6]) begin
                    tag_next   = in_byte[5:0];
                    phase_next = PH_NLEN;
                end else begin
                    tag_next     = {2'b00, in_byte[5:2]};
                    pkt_len_next = 32'd0;
                    open_next    = 1'b0;
                    case (in_byte[1:0])
                        2'd0: begin
                            hdr_cnt_next = 3'd1;
                            phase_next   = PH_LENB;
                        end
                        2'd1: begin
                            hdr_cnt_next = 3'd2;
                            phase_next   = PH_LENB;
                        end
                        2'd2: begin
                            hdr_cnt_next = 3'd4;
                            phase_next   = PH_LENB;
                        end
                        default: begin
                            open_next = 1'b1;
                            do_enter  = 1'b1;
                        end
                    endcase
                end
            end
            PH_NLEN: begin
                open_next = 1'b0;
                if (in_byte < 8'd192) begin
                    pkt_len_next = 32'(in_byte);
                    do_enter     = 1'b1;
                end else if (in_byte < 8'd224) begin
                    pkt_len_next = {18'd0, in_byte[5:0] - 6'd0, 8'd0};
                    phase_next   = PH_N2;
                end else if (in_byte == 8'd255) begin
                    pkt_len_next = 32'd0;
                    hdr_cnt_next = 3'd4;
                    phase_next   = PH_LENB;
                end else begin
                    err_next   = ST_PARTIAL;
                    phase_next = PH_ERR;
                end
            end
            PH_N2: begin
                pkt_len_next = pkt_len_reg + 32'(in_byte) + 32'd192;
                do_enter     = 1'b1;
            end
            PH_LENB: begin
                pkt_len_next = {pkt_len_reg[23:0], in_byte};
                hdr_cnt_next = hdr_cnt_reg - 3'd1;
                do_enter     = (hdr_cnt_next == 3'd0);
            end
            PH_SKIP: begin
                offset_next = off_inc;
                if (!open_reg && off_inc == pkt_len_reg)
                    phase_next = PH_TAG;
            end
            PH_BODY: begin
                if (!finished_reg) begin
                    if (offset_reg == 32'd0) begin
                        ver_ok_next = (in_byte == PKESK_VER);
                    end else if (offset_reg <= 32'd8) begin
                        emit      = ver_ok_reg;
                        emit_kind = KIND_KEYID;
                        emit_pos  = offset_reg[7:0] - 8'd1;
                    end else if (offset_reg == 32'd9) begin
                        algo_ok_next = (in_byte == ALGO_ECDH);
                    end else if (offset_reg == 32'd10) begin
                        mpi_hi_next = in_byte;
                    end else if (offset_reg == 32'd11) begin
                        nb_next = NB_W'(({1'b0, mpi_hi_reg, in_byte} + 17'd7) >> 3);
                    end else if (offset_reg < 32'(pt_end)) begin
                        if (offset_reg == 32'd12) begin
                            prefix_ok_next = (in_byte == POINT_UNCMP);
                        end else begin
                            emit      = point_ok;
                            emit_kind = KIND_POINT;
                            emit_pos  = offset_reg[7:0] - 8'd13;
                        end
                    end else if (offset_reg == 32'(pt_end)) begin
                        key_len_next = in_byte;
                        key_end_next = pt_end + END_W'(1) + END_W'(in_byte);
                    end else if (offset_reg < 32'(key_end_reg)) begin
                        emit      = point_ok && (32'(key_len_reg) <= 32'(KEY_CAPACITY));
                        emit_kind = KIND_WRAP;
                        emit_pos  = offset_reg[7:0] - 8'd13 - nb_reg[7:0];
                    end
                    offset_next = off_inc;
                    if (!open_reg && off_inc == pkt_len_reg)
                        finished_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_enter) begin
            offset_next = 32'd0;
            if (tag_next == TAG_PKESK) begin
                phase_next = PH_BODY;
                if (!open_next && pkt_len_next == 32'd0)
                    finished_next = 1'b1;
            end else if (!open_next && pkt_len_next == 32'd0) begin
                phase_next = PH_TAG;
            end else begin
                phase_next = PH_SKIP;
            end
        end
    end

    assign pt_end_next = END_W'(nb_next) + END_W'(12);

    always_comb begin
        if (offset_next < 32'd10)
            judge_st = ST_SHORT;
        else if (!ver_ok_next)
            judge_st = ST_VERSION;
        else if (!algo_ok_next)
            judge_st = ST_ALGO;
        else if (offset_next < 32'(pt_end_next))
            judge_st = ST_MPI;
        else if (nb_next != POINT_BYTES || !prefix_ok_next)
            judge_st = ST_POINT;
        else if (offset_next <= 32'(pt_end_next))
            judge_st = ST_SPACE;
        else if (offset_next < 32'(key_end_next))
            judge_st = ST_KEYBOUNDS;
        else if (32'(key_len_next) > 32'(KEY_CAPACITY))
            judge_st = ST_SIZE;
        else
            judge_st = ST_OK;

        case (phase_next)
            PH_ERR:  final_st = err_next;
            PH_TAG:  final_st = ST_NOTFOUND;
            PH_SKIP: final_st = open_next ? ST_NOTFOUND : ST_OVERRUN;
            PH_BODY: final_st = (!finished_next && !open_next) ? ST_OVERRUN : judge_st;
            default: final_st = ST_TRUNC;
        endcase
    end

    always_comb begin
        res = '0;
        if (in_last) begin
            res.valid     = in_en;
            res.final_res = 1'b1;
            res.status    = final_st;
            if (emit && final_st == ST_OK) begin
                res.kind     = emit_kind;
                res.position = emit_pos;
                res.value    = in_byte;
            end else begin
                res.kind = KIND_STATUS;
            end
        end else begin
            res.valid    = in_en && emit;
            res.kind     = emit_kind;
            res.position = emit_pos;
            res.value    = in_byte;
            res.status   = ST_OK;
        end
    end

    // last word rearms the parser as after reset
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_en && in_last)) begin
            phase_reg     <= PH_TAG;
            hdr_cnt_reg   <= '0;
            pkt_len_reg   <= '0;
            offset_reg    <= '0;
            tag_reg       <= '0;
            open_reg      <= 1'b0;
            mpi_hi_reg    <= '0;
            nb_reg        <= '0;
            key_len_reg   <= '0;
            key_end_reg   <= '0;
            finished_reg  <= 1'b0;
            err_reg       <= ST_OK;
            ver_ok_reg    <= 1'b0;
            algo_ok_reg   <= 1'b0;
            prefix_ok_reg <= 1'b0;
        end else if (in_en) begin
            phase_reg     <= phase_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            pkt_len_reg   <= pkt_len_next;
            offset_reg    <= offset_next;
            tag_reg       <= tag_next;
            open_reg      <= open_next;
            mpi_hi_reg    <= mpi_hi_next;
            nb_reg        <= nb_next;
            key_len_reg   <= key_len_next;
            key_end_reg   <= key_end_next;
            finished_reg  <= finished_next;
            err_reg       <= err_next;
            ver_ok_reg    <= ver_ok_next;
            algo_ok_reg   <= algo_ok_next;
            prefix_ok_reg <= prefix_ok_next;
        end
    end

    `PKESK_ASSERT_IMP(a_finished_in_body, finished_reg, phase_reg == PH_BODY)
    `PKESK_ASSERT_IMP(a_lenb_count, phase_reg == PH_LENB, hdr_cnt_reg != 3'd0)
    `PKESK_ASSERT_IMP(a_err_code, phase_reg == PH_ERR, err_reg == ST_TAG || err_reg == ST_PARTIAL)

endmodule
